### src/smq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smq_pkg - shared types and constants of the side marker qualifier
// Field widths, action and marker codes, register indexes, reset values and
// the small distance helpers used by the channels and the top level.
// ----------------------------------------------------------------------------
package smq_pkg;

  // Width of the encoder distance arithmetic (16 to 32)
  localparam int DistW   = 32;
  localparam int TravelW = 32;
  localparam int CfgW    = 24;
  localparam int RegIdxW = 3;
  localparam int CmpW    = ((DistW > CfgW) ? DistW : CfgW) + 1;

  typedef logic [DistW-1:0]       dist_t;
  typedef logic [CfgW-1:0]        cfg_t;
  typedef logic [RegIdxW-1:0]     reg_idx_t;
  typedef logic [1:0]             code_t;
  typedef logic signed [CmpW-1:0] cmp_t;

  // Item actions; code 3 carries no meaning and is ignored
  typedef enum logic [1:0] {
    ActSample  = 2'd0,
    ActCheck   = 2'd1,
    ActDiscard = 2'd2
  } action_t;

  // Marker codes (also the bit layout of the paired reaction)
  localparam code_t CodeNone  = 2'd0;
  localparam code_t CodeRight = 2'd1;
  localparam code_t CodeLeft  = 2'd2;
  localparam code_t CodeCross = 2'd3;

  // Phase bookkeeping: both emitter phases present
  localparam logic [1:0] PhaseOff   = 2'b01;
  localparam logic [1:0] PhaseOn    = 2'b10;
  localparam logic [1:0] BothPhases = 2'b11;

  // Register indexes
  localparam reg_idx_t RegShortGap   = 3'd0;
  localparam reg_idx_t RegGlitchLen  = 3'd1;
  localparam reg_idx_t RegQualifyLen = 3'd2;
  localparam reg_idx_t RegRightLow   = 3'd3;
  localparam reg_idx_t RegRightHigh  = 3'd4;
  localparam reg_idx_t RegRightClear = 3'd5;
  localparam reg_idx_t RegLeftClear  = 3'd6;
  localparam reg_idx_t RegInitOffset = 3'd7;

  // Register reset values
  localparam cfg_t RstShortGap   = 24'd5;
  localparam cfg_t RstGlitchLen  = 24'd10;
  localparam cfg_t RstQualifyLen = 24'd20;
  localparam cfg_t RstRightLow   = 24'd50;
  localparam cfg_t RstRightHigh  = 24'd60;
  localparam cfg_t RstRightClear = 24'd100;
  localparam cfg_t RstLeftClear  = 24'd80;
  localparam cfg_t RstInitOffset = 24'd100;

  // Map a register value onto the distance width
  function automatic dist_t dist_of_cfg(cfg_t c);
    logic [CfgW+DistW-1:0] w;
    w = {{DistW{1'b0}}, c};
    return w[DistW-1:0];
  endfunction

  // Signed distance strictly greater than an unsigned register value
  function automatic logic dist_gt(dist_t d, cfg_t c);
    cmp_t sd;
    cmp_t uc;
    sd = cmp_t'({{(CmpW-DistW){d[DistW-1]}}, d});
    uc = cmp_t'({{(CmpW-CfgW){1'b0}}, c});
    return sd > uc;
  endfunction

endpackage

### src/smq_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smq_item_if - input item channel
// Valid/ready channel carrying one sensor sample, distance check or discard.
// ----------------------------------------------------------------------------
interface smq_item_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          action;
  logic                                phase;
  logic                                left_pin;
  logic                                right_pin;
  logic signed [smq_pkg::TravelW-1:0]  travel;

  modport source (output valid, action, phase, left_pin, right_pin, travel, input ready);
  modport sink   (input valid, action, phase, left_pin, right_pin, travel, output ready);
endinterface

### src/smq_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smq_result_if - result channel
// Valid/ready channel carrying the marker code and the paired reaction.
// ----------------------------------------------------------------------------
interface smq_result_if;
  logic                 valid;
  logic                 ready;
  smq_pkg::code_t       marker_code;
  logic [1:0]           raw_markers;

  modport source (output valid, marker_code, raw_markers, input ready);
  modport sink   (input valid, marker_code, raw_markers, output ready);
endinterface

### src/smq_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smq_cfg_if - register write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface smq_cfg_if;
  logic                 valid;
  logic                 ready;
  smq_pkg::reg_idx_t    index;
  smq_pkg::cfg_t        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/side_marker_qualifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// side_marker_qualifier - left/right track marker qualifier
// Pairs emitter-off/emitter-on sensor samples, qualifies marker reactions
// over encoder distance and reports right, left or crossing codes.
// ----------------------------------------------------------------------------
//  Channel   Role   Beat contents
//  item      sink   action, phase, left_pin, right_pin, travel
//  result    source marker_code, raw_markers (one beat per item beat)
//  cfg       sink   index, data (register write, always ready)
//
//  An item beat passes the input register, then the qualify logic and the
//  result register. One item per cycle is sustained while results are taken;
//  the state update of one item completes before the next leaves the input
//  register.
//  Reset (rst, synchronous) restores registers and state; no clearing pass.
//  A stalled result holds; the input register keeps accepting while the
//  result register is free or being drained in the same cycle.
// ----------------------------------------------------------------------------
module side_marker_qualifier (
  input  logic         clk,
  input  logic         rst,
  smq_item_if.sink     item,
  smq_result_if.source result,
  smq_cfg_if.sink      cfg
);

  // Configuration registers
  smq_pkg::cfg_t  short_gap;
  smq_pkg::cfg_t  glitch_length;
  smq_pkg::cfg_t  qualify_length;
  smq_pkg::cfg_t  right_window_low;
  smq_pkg::cfg_t  right_window_high;
  smq_pkg::cfg_t  right_clear_of_left;
  smq_pkg::cfg_t  left_clear_of_right;

  // Input register
  logic                  hold_valid;
  logic [1:0]            hold_action;
  logic                  hold_phase;
  logic                  hold_left;
  logic                  hold_right;
  smq_pkg::dist_t        hold_travel;

  // Qualifier state
  logic                  left_lit,  left_lit_next;
  logic                  right_lit, right_lit_next;
  logic                  left_dark, left_dark_next;
  logic                  right_dark, right_dark_next;
  logic [1:0]            phases_seen, phases_seen_next;
  smq_pkg::code_t        paired_reaction, paired_reaction_next;
  logic                  measuring, measuring_next;
  smq_pkg::code_t        candidate_code, candidate_code_next;
  smq_pkg::dist_t        measure_start, measure_start_next;
  smq_pkg::dist_t        left_mark_pos, left_mark_pos_next;
  smq_pkg::dist_t        right_mark_pos, right_mark_pos_next;
  smq_pkg::code_t        code_next;

  // Result register
  logic                  result_valid;
  smq_pkg::code_t        marker_code;
  logic [1:0]            raw_markers;

  // Working values
  logic                  advance;
  logic                  start;
  logic                  left_moved;
  logic                  right_moved;
  logic [1:0]            seen;
  smq_pkg::dist_t        start_pos;
  smq_pkg::dist_t        d_meas;
  smq_pkg::dist_t        dl;
  smq_pkg::dist_t        dr;
  smq_pkg::code_t        pair;

  // Handshake: move an item on when the result register is free or draining
  assign advance      = hold_valid && (!result_valid || result.ready);
  assign item.ready   = !hold_valid || advance;
  assign cfg.ready    = 1'b1;
  assign result.valid       = result_valid;
  assign result.marker_code = marker_code;
  assign result.raw_markers = raw_markers;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item.ready) begin
      hold_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      hold_action <= item.action;
      hold_phase  <= item.phase;
      hold_left   <= item.left_pin;
      hold_right  <= item.right_pin;
      hold_travel <= item.travel[smq_pkg::DistW-1:0];
    end
  end

  // Qualify logic for the held item
  always_comb begin
    left_lit_next        = left_lit;
    right_lit_next       = right_lit;
    left_dark_next       = left_dark;
    right_dark_next      = right_dark;
    phases_seen_next     = phases_seen;
    paired_reaction_next = paired_reaction;
    measuring_next       = measuring;
    candidate_code_next  = candidate_code;
    measure_start_next   = measure_start;
    left_mark_pos_next   = left_mark_pos;
    right_mark_pos_next  = right_mark_pos;
    code_next            = smq_pkg::CodeNone;
    seen                 = phases_seen;
    pair                 = smq_pkg::CodeNone;
    left_moved           = 1'b0;
    right_moved          = 1'b0;

    // Start measuring when a reaction appears
    start     = (paired_reaction != smq_pkg::CodeNone) && !measuring;
    start_pos = start ? hold_travel : measure_start;
    d_meas    = hold_travel - start_pos;

    case (hold_action)
      smq_pkg::ActSample: begin
        if (hold_phase) begin
          left_lit_next  = hold_left;
          right_lit_next = hold_right;
          seen           = phases_seen | smq_pkg::PhaseOn;
        end else begin
          left_dark_next  = hold_left;
          right_dark_next = hold_right;
          seen            = phases_seen | smq_pkg::PhaseOff;
        end
        phases_seen_next = seen;
        if (seen == smq_pkg::BothPhases) begin
          pair[0] = right_dark_next && !right_lit_next;
          pair[1] = left_dark_next && !left_lit_next;
          paired_reaction_next = pair;
          phases_seen_next     = 2'b00;
        end
      end

      smq_pkg::ActCheck: begin
        if (start) begin
          candidate_code_next = paired_reaction;
          measuring_next      = 1'b1;
          measure_start_next  = hold_travel;
        end
        if (start || measuring) begin
          if (!smq_pkg::dist_gt(d_meas, qualify_length)) begin
            // Drop a reaction that fades early; otherwise keep the strongest
            if (paired_reaction == smq_pkg::CodeNone &&
                !smq_pkg::dist_gt(d_meas, glitch_length)) begin
              candidate_code_next = smq_pkg::CodeNone;
              measuring_next      = 1'b0;
            end
            if (paired_reaction > candidate_code_next) begin
              candidate_code_next = paired_reaction;
            end
          end else begin
            // Accept: store the mark position
            right_moved = (candidate_code_next == smq_pkg::CodeRight) ||
                          (candidate_code_next == smq_pkg::CodeCross);
            left_moved  = (candidate_code_next == smq_pkg::CodeLeft) ||
                          (candidate_code_next == smq_pkg::CodeCross);
            if (right_moved) begin
              right_mark_pos_next = hold_travel;
            end
            if (left_moved) begin
              left_mark_pos_next = hold_travel;
            end
            measuring_next = 1'b0;
          end
        end
      end

      smq_pkg::ActDiscard: begin
        phases_seen_next     = 2'b00;
        paired_reaction_next = smq_pkg::CodeNone;
      end

      default: begin
      end
    endcase

    // Distances from the marks, zero where a mark moved to this position
    dl = left_moved  ? '0 : hold_travel - left_mark_pos;
    dr = right_moved ? '0 : hold_travel - right_mark_pos;

    if (hold_action == smq_pkg::ActCheck) begin
      if (smq_pkg::dist_gt(dr, right_window_low) &&
          !smq_pkg::dist_gt(dr, right_window_high) &&
          smq_pkg::dist_gt(dl, right_clear_of_left)) begin
        code_next = smq_pkg::CodeRight;
      end
      if (smq_pkg::dist_gt(dl, short_gap) &&
          !smq_pkg::dist_gt(dl, glitch_length) &&
          smq_pkg::dist_gt(dr, left_clear_of_right)) begin
        code_next = smq_pkg::CodeLeft;
      end
      if (smq_pkg::dist_gt(dl, glitch_length) &&
          !smq_pkg::dist_gt(dl, qualify_length) && (dr == dl)) begin
        code_next = smq_pkg::CodeCross;
      end
    end
  end

  // State and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      short_gap           <= smq_pkg::RstShortGap;
      glitch_length       <= smq_pkg::RstGlitchLen;
      qualify_length      <= smq_pkg::RstQualifyLen;
      right_window_low    <= smq_pkg::RstRightLow;
      right_window_high   <= smq_pkg::RstRightHigh;
      right_clear_of_left <= smq_pkg::RstRightClear;
      left_clear_of_right <= smq_pkg::RstLeftClear;
      left_lit            <= 1'b1;
      right_lit           <= 1'b1;
      left_dark           <= 1'b1;
      right_dark          <= 1'b1;
      phases_seen         <= 2'b00;
      paired_reaction     <= smq_pkg::CodeNone;
      measuring           <= 1'b0;
      candidate_code      <= smq_pkg::CodeNone;
      measure_start       <= '0;
      left_mark_pos       <= smq_pkg::dist_of_cfg(smq_pkg::RstInitOffset);
      right_mark_pos      <= smq_pkg::dist_of_cfg(smq_pkg::RstInitOffset) +
                             smq_pkg::DistW'(1);
    end else begin
      if (advance) begin
        left_lit        <= left_lit_next;
        right_lit       <= right_lit_next;
        left_dark       <= left_dark_next;
        right_dark      <= right_dark_next;
        phases_seen     <= phases_seen_next;
        paired_reaction <= paired_reaction_next;
        measuring       <= measuring_next;
        candidate_code  <= candidate_code_next;
        measure_start   <= measure_start_next;
        left_mark_pos   <= left_mark_pos_next;
        right_mark_pos  <= right_mark_pos_next;
      end
      // The user must make register writes only while idle (unenforced); the offset reloads both marks
      if (cfg.valid) begin
        case (cfg.index)
          smq_pkg::RegShortGap:   short_gap           <= cfg.data;
          smq_pkg::RegGlitchLen:  glitch_length       <= cfg.data;
          smq_pkg::RegQualifyLen: qualify_length      <= cfg.data;
          smq_pkg::RegRightLow:   right_window_low    <= cfg.data;
          smq_pkg::RegRightHigh:  right_window_high   <= cfg.data;
          smq_pkg::RegRightClear: right_clear_of_left <= cfg.data;
          smq_pkg::RegLeftClear:  left_clear_of_right <= cfg.data;
          smq_pkg::RegInitOffset: begin
            left_mark_pos       <= smq_pkg::dist_of_cfg(cfg.data);
            right_mark_pos      <= smq_pkg::dist_of_cfg(cfg.data) + smq_pkg::DistW'(1);
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      marker_code <= code_next;
      raw_markers <= paired_reaction_next;
    end
  end

  // Checks
  a_no_stored_pair: assert property (@(posedge clk) disable iff (rst)
    phases_seen != smq_pkg::BothPhases)
    else $error("both phases left pending after pairing");

  a_candidate_set: assert property (@(posedge clk) disable iff (rst)
    measuring |-> (candidate_code != smq_pkg::CodeNone))
    else $error("measuring without a candidate code");

  a_non_check_quiet: assert property (@(posedge clk) disable iff (rst)
    (advance && hold_action != smq_pkg::ActCheck) |=>
      (marker_code == smq_pkg::CodeNone))
    else $error("marker code reported for a non-check item");

  a_discard_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && hold_action == smq_pkg::ActDiscard) |=>
      (raw_markers == smq_pkg::CodeNone && phases_seen == 2'b00))
    else $error("discard left pending samples");

  a_free_moves: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && !result_valid) |-> advance)
    else $error("held item stalled with an empty result register");

endmodule

### tb/sv/tb_side_marker_qualifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_side_marker_qualifier - self-checking bench for the side marker qualifier
// Drives sensor samples, distance checks and discards through the item
// channel and predicts every result beat with a bit-accurate model of the
// sample pairing, marker qualification and report windows. The run steps
// through eight register settings (reset values, all zero, all ones, random)
// and four idling patterns, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_side_marker_qualifier;
  import smq_pkg::*;

  localparam logic [1:0] ActUnused   = 2'd3;
  localparam int         CycleLimit  = 200000;
  localparam int         PhaseItems  = 140;
  localparam int         NumSettings = 8;
  localparam int         DrainCycles = 4;
  localparam int         HoldOff     = 300;

  typedef struct packed {
    code_t      marker_code;
    logic [1:0] raw_markers;
  } marker_beat_t;

  // Predicts marker codes and paired reactions, and checks result beats
  class marker_scoreboard;
    cfg_t         regs [8];
    bit           left_lit, right_lit, left_dark, right_dark;
    logic [1:0]   phases_seen;
    code_t        reaction, candidate;
    bit           measuring;
    dist_t        measure_start, left_mark, right_mark;
    marker_beat_t expected_beats [$];
    int           errors, results_seen, marks_taken;
    int           code_tally [4];

    function new();
      regs[RegShortGap]   = RstShortGap;
      regs[RegGlitchLen]  = RstGlitchLen;
      regs[RegQualifyLen] = RstQualifyLen;
      regs[RegRightLow]   = RstRightLow;
      regs[RegRightHigh]  = RstRightHigh;
      regs[RegRightClear] = RstRightClear;
      regs[RegLeftClear]  = RstLeftClear;
      regs[RegInitOffset] = RstInitOffset;
      left_lit      = 1'b1;
      right_lit     = 1'b1;
      left_dark     = 1'b1;
      right_dark    = 1'b1;
      phases_seen   = '0;
      reaction      = CodeNone;
      candidate     = CodeNone;
      measuring     = 1'b0;
      measure_start = '0;
      reload_marks();
    endfunction

    function void reload_marks();
      left_mark  = dist_t'(regs[RegInitOffset]);
      right_mark = left_mark + dist_t'(1);
    endfunction

    function void write_reg(reg_idx_t idx, cfg_t value);
      regs[idx] = value;
      if (idx == RegInitOffset) reload_marks();
    endfunction

    // Signed distance between two encoder readings, wrapping at the width
    function longint span(dist_t later, dist_t earlier);
      dist_t d;
      d = later - earlier;
      return longint'($signed(d));
    endfunction

    function longint reg_val(reg_idx_t idx);
      return longint'(regs[idx]);
    endfunction

    // Qualify the current reaction over distance, then pick the report code
    function code_t measure(dist_t t);
      code_t  live;
      code_t  code;
      longint d, dl, dr;
      live = reaction;
      code = CodeNone;
      if (live != CodeNone && !measuring) begin
        candidate     = live;
        measuring     = 1'b1;
        measure_start = t;
      end
      if (measuring) begin
        d = span(t, measure_start);
        if (d <= reg_val(RegQualifyLen)) begin
          // drop a reaction that faded early
          if (live == CodeNone && d <= reg_val(RegGlitchLen)) begin
            candidate = CodeNone;
            measuring = 1'b0;
          end
          if (live > candidate) candidate = live;
        end else begin
          if (candidate == CodeRight || candidate == CodeCross) right_mark = t;
          if (candidate == CodeLeft || candidate == CodeCross) left_mark = t;
          if (candidate != CodeNone) marks_taken++;
          measuring = 1'b0;
        end
      end
      dl = span(t, left_mark);
      dr = span(t, right_mark);
      if (dr > reg_val(RegRightLow) && dr <= reg_val(RegRightHigh) &&
          dl > reg_val(RegRightClear))
        code = CodeRight;
      if (dl > reg_val(RegShortGap) && dl <= reg_val(RegGlitchLen) &&
          dr > reg_val(RegLeftClear))
        code = CodeLeft;
      if (dl > reg_val(RegGlitchLen) && dl <= reg_val(RegQualifyLen) && dr == dl)
        code = CodeCross;
      return code;
    endfunction

    // Note an accepted item beat and queue the result it must produce
    function void note_item(logic [1:0] act, logic ph, logic lp, logic rp,
                            logic [TravelW-1:0] trv);
      marker_beat_t beat;
      code_t        r;
      beat.marker_code = CodeNone;
      case (act)
        ActSample: begin
          if (ph) begin
            left_lit  = lp;
            right_lit = rp;
          end else begin
            left_dark  = lp;
            right_dark = rp;
          end
          phases_seen = phases_seen | (ph ? PhaseOn : PhaseOff);
          if (phases_seen == BothPhases) begin
            r = CodeNone;
            if (right_dark && !right_lit) r = r | CodeRight;
            if (left_dark && !left_lit) r = r | CodeLeft;
            reaction    = r;
            phases_seen = '0;
          end
        end
        ActCheck: beat.marker_code = measure(dist_t'(trv));
        ActDiscard: begin
          phases_seen = '0;
          reaction    = CodeNone;
        end
        default: ;
      endcase
      beat.raw_markers = reaction;
      expected_beats.push_back(beat);
    endfunction

    // Compare a result beat with the oldest expectation
    function void check_result(code_t code, logic [1:0] raw);
      marker_beat_t exp_beat;
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected: marker_code %0d raw_markers %0d",
               code, raw);
        errors++;
        return;
      end
      exp_beat = expected_beats.pop_front();
      results_seen++;
      code_tally[exp_beat.marker_code]++;
      if (code !== exp_beat.marker_code) begin
        $error("marker_code: expected %0d, actual %0d", exp_beat.marker_code, code);
        errors++;
      end
      if (raw !== exp_beat.raw_markers) begin
        $error("raw_markers: expected %0d, actual %0d", exp_beat.raw_markers, raw);
        errors++;
      end
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  smq_item_if   item_ch ();
  smq_result_if result_ch ();
  smq_cfg_if    cfg_ch ();

  side_marker_qualifier u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  marker_scoreboard sb = new();

  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 hold_off_left = 0;
  int                 cycles = 0;
  int                 items_sent = 0;
  cfg_t               cur_cfg [8];
  code_t              side_pattern = CodeNone;
  logic [TravelW-1:0] odometer = '0;

  always #10 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Observe beats on all three channels
  always @(posedge clk) begin
    if (!rst) begin
      if (item_ch.valid && item_ch.ready)
        sb.note_item(item_ch.action, item_ch.phase, item_ch.left_pin,
                     item_ch.right_pin, item_ch.travel);
      if (result_ch.valid && result_ch.ready)
        sb.check_result(result_ch.marker_code, result_ch.raw_markers);
      if (cfg_ch.valid && cfg_ch.ready)
        sb.write_reg(cfg_ch.index, cfg_ch.data);
    end
  end

  // Result receiver: random stalls, plus a counted hold-off when requested
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_off_left = hold_off_left - 1;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one item beat and hold it until accepted
  task automatic send_item(input logic [1:0] act, input logic ph, input logic lp,
                           input logic rp, input logic [TravelW-1:0] trv);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.action    <= act;
    item_ch.phase     <= ph;
    item_ch.left_pin  <= lp;
    item_ch.right_pin <= rp;
    item_ch.travel    <= trv;
    do @(posedge clk); while (!item_ch.ready);
    if (act != ActUnused) items_sent++;
  endtask

  // Write every register from cur_cfg while the block is idle
  task automatic program_registers();
    for (int i = 0; i < 8; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= reg_idx_t'(i);
      cfg_ch.data  <= cur_cfg[i];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait until every expected result has arrived, then let the pipe settle
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Random traffic: mostly sample pairs and advancing checks, some noise
  task automatic run_phase(input int count);
    int   stop_at;
    int   sel;
    int   step;
    cfg_t span_lim;
    logic dl, dr, ll, lr;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 28) begin
        // well-formed pair of emitter phases around a chosen reaction
        if ($urandom_range(9) < 3) side_pattern = code_t'($urandom_range(3));
        dl = side_pattern[1] | 1'($urandom_range(1));
        dr = side_pattern[0] | 1'($urandom_range(1));
        ll = side_pattern[1] ? 1'b0 : (dl | 1'($urandom_range(1)));
        lr = side_pattern[0] ? 1'b0 : (dr | 1'($urandom_range(1)));
        if ($urandom_range(19) == 0)
          send_item(ActSample, 1'($urandom_range(1)), 1'($urandom_range(1)),
                    1'($urandom_range(1)), $urandom());
        if ($urandom_range(9) == 0) begin
          send_item(ActSample, 1'b1, ll, lr, $urandom());
          send_item(ActSample, 1'b0, dl, dr, $urandom());
        end else begin
          send_item(ActSample, 1'b0, dl, dr, $urandom());
          send_item(ActSample, 1'b1, ll, lr, $urandom());
        end
      end else if (sel < 88) begin
        // advance the odometer on the scale of one of the windows
        case ($urandom_range(3))
          0:       span_lim = cur_cfg[RegGlitchLen];
          1:       span_lim = cur_cfg[RegQualifyLen];
          2:       span_lim = cur_cfg[RegRightHigh];
          default: span_lim = cur_cfg[RegRightClear];
        endcase
        step = $urandom_range(0, span_lim / 3 + 2);
        if ($urandom_range(9) == 0) odometer = odometer - step;
        else odometer = odometer + step;
        send_item(ActCheck, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), odometer);
      end else if (sel < 92) begin
        send_item(ActDiscard, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), $urandom());
      end else if (sel < 96) begin
        send_item(ActSample, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), $urandom());
      end else if (sel < 98) begin
        send_item(ActUnused, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), $urandom());
      end else begin
        odometer = $urandom();
        send_item(ActCheck, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), odometer);
      end
    end
    item_ch.valid <= 1'b0;
  endtask

  // Main sequence
  initial begin
    item_ch.valid     <= 1'b0;
    item_ch.action    <= ActSample;
    item_ch.phase     <= 1'b0;
    item_ch.left_pin  <= 1'b0;
    item_ch.right_pin <= 1'b0;
    item_ch.travel    <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= RegShortGap;
    cfg_ch.data       <= '0;
    cur_cfg[RegShortGap]   = RstShortGap;
    cur_cfg[RegGlitchLen]  = RstGlitchLen;
    cur_cfg[RegQualifyLen] = RstQualifyLen;
    cur_cfg[RegRightLow]   = RstRightLow;
    cur_cfg[RegRightHigh]  = RstRightHigh;
    cur_cfg[RegRightClear] = RstRightClear;
    cur_cfg[RegLeftClear]  = RstLeftClear;
    cur_cfg[RegInitOffset] = RstInitOffset;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: unused action, repeated phase, crossing, left, right mark qualified
    send_item(ActUnused, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_item(ActCheck, 1'b0, 1'b0, 1'b0, 32'h8000_0000);
    send_item(ActSample, 1'b1, 1'b1, 1'b1, '0);
    send_item(ActSample, 1'b1, 1'b0, 1'b0, '0);
    send_item(ActSample, 1'b0, 1'b1, 1'b1, '0);
    send_item(ActCheck, 1'b0, 1'b0, 1'b0, 32'd1000);
    send_item(ActCheck, 1'b0, 1'b0, 1'b0, 32'd1021);
    send_item(ActCheck, 1'b0, 1'b0, 1'b0, 32'd1032);
    send_item(ActSample, 1'b0, 1'b1, 1'b0, '0);
    send_item(ActSample, 1'b1, 1'b0, 1'b0, '0);
    send_item(ActCheck, 1'b1, 1'b1, 1'b1, 32'h7FFF_FFFF);
    send_item(ActCheck, 1'b0, 1'b0, 1'b0, 32'h7FFF_FFFF + 32'd100);
    send_item(ActDiscard, 1'b0, 1'b0, 1'b0, '0);
    send_item(ActCheck, 1'b0, 1'b0, 1'b0, 32'h7FFF_FFFF + 32'd108);
    send_item(ActSample, 1'b0, 1'b1, 1'b0, '0);
    send_item(ActSample, 1'b1, 1'b0, 1'b0, '0);
    send_item(ActCheck, 1'b0, 1'b0, 1'b0, 32'h7FFF_FFFF + 32'd1000);
    send_item(ActCheck, 1'b0, 1'b0, 1'b0, 32'h7FFF_FFFF + 32'd1025);
    send_item(ActCheck, 1'b0, 1'b0, 1'b0, 32'h7FFF_FFFF + 32'd1031);
    send_item(ActSample, 1'b0, 1'b0, 1'b1, '0);
    send_item(ActSample, 1'b1, 1'b0, 1'b0, '0);
    send_item(ActCheck, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFF0);
    send_item(ActCheck, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFF0 + 32'd100);
    send_item(ActCheck, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFF0 + 32'd130);
    send_item(ActCheck, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFF0 + 32'd185);
    item_ch.valid <= 1'b0;
    drain();

    // Random phases, each with its own register setting and idling pattern
    for (int p = 0; p < NumSettings; p++) begin
      if (p != 0) begin
        case (p)
          1: foreach (cur_cfg[i]) cur_cfg[i] = '0;
          2: foreach (cur_cfg[i]) cur_cfg[i] = '1;
          5: begin
            cur_cfg[RegShortGap]   = RstShortGap;
            cur_cfg[RegGlitchLen]  = RstGlitchLen;
            cur_cfg[RegQualifyLen] = RstQualifyLen;
            cur_cfg[RegRightLow]   = RstRightLow;
            cur_cfg[RegRightHigh]  = RstRightHigh;
            cur_cfg[RegRightClear] = RstRightClear;
            cur_cfg[RegLeftClear]  = RstLeftClear;
            cur_cfg[RegInitOffset] = RstInitOffset;
          end
          3, 6: begin
            // ordered windows of plausible size, so every code can fire
            cur_cfg[RegShortGap]   = cfg_t'($urandom_range(0, 20));
            cur_cfg[RegGlitchLen]  = cur_cfg[RegShortGap] + cfg_t'($urandom_range(0, 20));
            cur_cfg[RegQualifyLen] = cur_cfg[RegGlitchLen] + cfg_t'($urandom_range(0, 40));
            cur_cfg[RegRightLow]   = cfg_t'($urandom_range(0, 200));
            cur_cfg[RegRightHigh]  = cur_cfg[RegRightLow] + cfg_t'($urandom_range(0, 50));
            cur_cfg[RegRightClear] = cfg_t'($urandom_range(0, 300));
            cur_cfg[RegLeftClear]  = cfg_t'($urandom_range(0, 300));
            cur_cfg[RegInitOffset] = cfg_t'($urandom());
          end
          default: foreach (cur_cfg[i]) cur_cfg[i] = cfg_t'($urandom());
        endcase
        program_registers();
      end
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 67;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 67;
        end
        default: begin
          send_idle_pct  = 17;
          recv_stall_pct = 17;
        end
      endcase
      // back-pressure: hold the receiver off while items keep coming
      if (p == 0) hold_off_left = HoldOff;
      run_phase(PhaseItems);
      drain();
    end

    drain();
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    $display("Covered %0d items over %0d register settings and four idling patterns",
             items_sent, NumSettings);
    $display("Results checked %0d: %0d right, %0d left, %0d crossing, %0d marks qualified",
             sb.results_seen, sb.code_tally[CodeRight], sb.code_tally[CodeLeft],
             sb.code_tally[CodeCross], sb.marks_taken);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
